// ===== hdl/fmtf_pkg.sv =====
// ----------------------------------------------------------------------------
// fmtf_pkg
// Shared types and constants of the message template filter.
// ----------------------------------------------------------------------------
package fmtf_pkg;

   localparam int unsigned HeaderBytes = 10;
   localparam int unsigned CountWidth  = 4;

   localparam logic [31:0] SeqLowerReset = 32'd731915;
   localparam logic [31:0] SeqUpperReset = 32'd732490;
   localparam logic [15:0] WantedReset   = 16'd145;

   // bit positions inside a body byte
   localparam int unsigned StopBitPos  = 7;
   localparam int unsigned PmapBitPos  = 6;

   // configuration register indexes
   typedef enum logic [1:0] {
      CSR_SEQ_LOWER = 2'd0,
      CSR_SEQ_UPPER = 2'd1,
      CSR_WANTED    = 2'd2
   } csr_index_type;

   // parser phase, one-hot
   typedef enum logic [3:0] {
      PH_HEADER = 4'b0001,
      PH_PMAP   = 4'b0010,
      PH_TMPL   = 4'b0100,
      PH_SKIP   = 4'b1000
   } phase_type;

   typedef struct packed {
      logic [31:0] seq_lower;
      logic [31:0] seq_upper;
      logic [15:0] wanted;
   } cfg_type;

   typedef struct packed {
      logic [31:0] seq_number;
      logic [15:0] chunk_count;
      logic [15:0] chunk_index;
      logic [15:0] body_length;
      logic [15:0] template_id;
      logic        template_found;
      logic        keep;
   } result_type;

endpackage

// ===== hdl/fmtf_parser.sv =====
// ----------------------------------------------------------------------------
// fmtf_parser
// Byte-at-a-time packet parser: header capture, presence map and template
// field decode, filter decision on the last byte of each packet.
// ----------------------------------------------------------------------------
module fmtf_parser
   import fmtf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       byte_valid,
   input  logic [7:0] byte_data,
   input  cfg_type    cfg,
   output logic       emit,
   output result_type result
);

   localparam logic [CountWidth-1:0] LastHeaderByte = CountWidth'(HeaderBytes - 1);

   phase_type             phase_ff, phase_in;
   logic [CountWidth-1:0] hdr_cnt_ff, hdr_cnt_in;
   logic [31:0]           seq_ff, seq_in;
   logic [15:0]           chunks_ff, chunks_in;
   logic [15:0]           index_ff, index_in;
   logic [15:0]           length_ff, length_in;
   logic [15:0]           left_ff, left_in;
   logic                  pmap_started_ff, pmap_started_in;
   logic                  tmpl_bit_ff, tmpl_bit_in;
   logic [15:0]           acc_ff, acc_in;
   logic [15:0]           tmpl_val_ff, tmpl_val_in;
   logic                  tmpl_seen_ff, tmpl_seen_in;

   logic        stop;
   logic        tbit_now;
   logic [15:0] new_length;
   logic        in_window;

   assign stop       = byte_data[StopBitPos];
   assign tbit_now   = pmap_started_ff ? tmpl_bit_ff : byte_data[PmapBitPos];
   assign new_length = {length_ff[7:0], byte_data};

   always_comb begin
      phase_in        = phase_ff;
      hdr_cnt_in      = hdr_cnt_ff;
      seq_in          = seq_ff;
      chunks_in       = chunks_ff;
      index_in        = index_ff;
      length_in       = length_ff;
      left_in         = left_ff;
      pmap_started_in = pmap_started_ff;
      tmpl_bit_in     = tmpl_bit_ff;
      acc_in          = acc_ff;
      tmpl_val_in     = tmpl_val_ff;
      tmpl_seen_in    = tmpl_seen_ff;
      emit            = 1'b0;

      if (byte_valid) begin
         unique case (phase_ff)
            PH_HEADER: begin
               hdr_cnt_in = hdr_cnt_ff + 1'b1;
               priority if (hdr_cnt_ff < CountWidth'(4)) begin
                  seq_in = {seq_ff[23:0], byte_data};
               end else if (hdr_cnt_ff < CountWidth'(6)) begin
                  chunks_in = {chunks_ff[7:0], byte_data};
               end else if (hdr_cnt_ff < CountWidth'(8)) begin
                  index_in = {index_ff[7:0], byte_data};
               end else begin
                  length_in = new_length;
               end
               if (hdr_cnt_ff == LastHeaderByte) begin
                  // header complete: start a fresh body
                  hdr_cnt_in      = '0;
                  pmap_started_in = 1'b0;
                  tmpl_bit_in     = 1'b0;
                  acc_in          = '0;
                  tmpl_val_in     = '0;
                  tmpl_seen_in    = 1'b0;
                  left_in         = new_length;
                  if (new_length == '0) begin
                     emit = 1'b1;
                  end else begin
                     phase_in = PH_PMAP;
                  end
               end
            end
            PH_PMAP: begin
               tmpl_bit_in     = tbit_now;
               pmap_started_in = 1'b1;
               if (stop) begin
                  pmap_started_in = 1'b0;
                  phase_in        = tbit_now ? PH_TMPL : PH_SKIP;
               end
            end
            PH_TMPL: begin
               // only the low 16 bits of the value are ever used
               acc_in = {acc_ff[8:0], byte_data[6:0]};
               if (stop) begin
                  tmpl_val_in  = acc_in;
                  tmpl_seen_in = 1'b1;
                  acc_in       = '0;
                  phase_in     = PH_SKIP;
               end
            end
            PH_SKIP: begin
            end
            default: begin
            end
         endcase

         if (phase_ff != PH_HEADER) begin
            left_in = left_ff - 1'b1;
            if (left_ff == 16'd1) begin
               emit     = 1'b1;
               phase_in = PH_HEADER;
            end
         end
      end
   end

   assign in_window = (seq_in > cfg.seq_lower) && (seq_in < cfg.seq_upper);

   always_comb begin
      result.seq_number     = seq_in;
      result.chunk_count    = chunks_in;
      result.chunk_index    = index_in;
      result.body_length    = length_in;
      result.template_found = tmpl_seen_in;
      result.template_id    = tmpl_seen_in ? tmpl_val_in : '0;
      result.keep           = in_window && tmpl_seen_in && (tmpl_val_in == cfg.wanted);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_HEADER;
         hdr_cnt_ff      <= '0;
         seq_ff          <= '0;
         chunks_ff       <= '0;
         index_ff        <= '0;
         length_ff       <= '0;
         left_ff         <= '0;
         pmap_started_ff <= 1'b0;
         tmpl_bit_ff     <= 1'b0;
         acc_ff          <= '0;
         tmpl_val_ff     <= '0;
         tmpl_seen_ff    <= 1'b0;
      end else begin
         phase_ff        <= phase_in;
         hdr_cnt_ff      <= hdr_cnt_in;
         seq_ff          <= seq_in;
         chunks_ff       <= chunks_in;
         index_ff        <= index_in;
         length_ff       <= length_in;
         left_ff         <= left_in;
         pmap_started_ff <= pmap_started_in;
         tmpl_bit_ff     <= tmpl_bit_in;
         acc_ff          <= acc_in;
         tmpl_val_ff     <= tmpl_val_in;
         tmpl_seen_ff    <= tmpl_seen_in;
      end
   end

endmodule

// ===== hdl/fast_message_template_filter.sv =====
// ----------------------------------------------------------------------------
// fast_message_template_filter
// Packet header capture and template filter for a FAST market data stream.
// ----------------------------------------------------------------------------
// The block takes one byte word per clock on the req_ channel and delivers
// one rsp_ word per packet, on the cycle after the packet's last byte is
// taken (the tenth header byte when the body length is zero). Each byte goes
// through one pass of parser logic straight into the parser state and the
// result register, so a byte can be accepted every cycle; the only thing
// that stops input is a finished result still waiting in the result register
// while rsp_ready is low. A packet is a 10-byte big-endian header (sequence
// number, chunk count, chunk index, body length) and a body of stop-bit
// fields. The first field is the presence map; when its first map bit is set
// the second field is the template ID. keep is set when the sequence number
// lies strictly between the two bounds and the template matches. Write the
// csr_ registers only while no packet is in progress.
// ----------------------------------------------------------------------------
module fast_message_template_filter
   import fmtf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // byte input
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   // packet result
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_seq_number,
   output logic [15:0] rsp_chunk_count,
   output logic [15:0] rsp_chunk_index,
   output logic [15:0] rsp_body_length,
   output logic [15:0] rsp_template_id,
   output logic        rsp_template_found,
   output logic        rsp_keep,
   // configuration
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   cfg_type    cfg_ff, cfg_in;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff, rsp_in;
   logic       accept;
   logic       emit;
   result_type result;

   // Take a new byte whenever the result register is free or drains this cycle.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // Configuration writes; an index past the register list is dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_SEQ_LOWER: cfg_in.seq_lower = csr_wdata;
            CSR_SEQ_UPPER: cfg_in.seq_upper = csr_wdata;
            CSR_WANTED:    cfg_in.wanted    = csr_wdata[15:0];
            default:       cfg_in           = cfg_ff;
         endcase
      end
   end

   fmtf_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (accept),
      .byte_data  (req_data_byte),
      .cfg        (cfg_ff),
      .emit       (emit),
      .result     (result)
   );

   // Result register: load on a finished packet, clear once the word is taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_in       = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.seq_lower <= SeqLowerReset;
         cfg_ff.seq_upper <= SeqUpperReset;
         cfg_ff.wanted    <= WantedReset;
         rsp_valid_ff     <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload: no reset needed
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_seq_number     = rsp_ff.seq_number;
   assign rsp_chunk_count    = rsp_ff.chunk_count;
   assign rsp_chunk_index    = rsp_ff.chunk_index;
   assign rsp_body_length    = rsp_ff.body_length;
   assign rsp_template_id    = rsp_ff.template_id;
   assign rsp_template_found = rsp_ff.template_found;
   assign rsp_keep           = rsp_ff.keep;

   // A held result must block further input, or a new word could overwrite it.
   a_hold_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !req_ready)
      else $error("input accepted while result word is stalled");

   // A kept packet always carries a decoded template.
   a_keep_needs_template: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_keep) |-> rsp_template_found)
      else $error("keep set without a template");

   // Without a template the reported ID reads as zero.
   a_absent_id_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_template_found) |-> (rsp_template_id == 16'd0))
      else $error("template ID nonzero while absent");

   // A result only appears after a byte was taken.
   a_result_from_byte: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(accept))
      else $error("result without an accepted byte");

endmodule
